FILE: hdl/rlm_pkg.sv
// Package of shared constants and types for the RSA letter exponentiation block.
package rlm_pkg;
    localparam int MOD_WIDTH_DEF = 32;
    localparam int DATA_W        = 32;
    localparam int CFG_IDX_W     = 2;
    localparam logic [31:0] LETTER_BASE = 32'd65;

    localparam logic [CFG_IDX_W-1:0] REG_PUB_EXP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRIV_EXP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // load base, exponent and accumulator
        logic mul_start;  // start a product acc*base
        logic sqr_start;  // start a product base*base
        logic red_start;  // start reduction of the initial base
        logic shift_exp;  // drop the exponent's low bit
    } rlm_cmd_t;

    typedef struct packed {
        logic busy;       // multiply or reduce unit at work
        logic exp_zero;
        logic exp_lsb;
    } rlm_status_t;
endpackage

FILE: hdl/rlm_stream_if.sv
// Valid/ready stream interface carrying the request and result payloads.
interface rlm_stream_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    logic         flag;
    modport source (output valid, output data, output flag, input ready);
    modport sink   (input valid, input data, input flag, output ready);
endinterface

FILE: hdl/rlm_datapath.sv
// Datapath: base, exponent and accumulator registers with a shift-add modular multiplier.
module rlm_datapath #(
    parameter int MOD_WIDTH = rlm_pkg::MOD_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rlm_pkg::rlm_cmd_t    cmd,
    input  logic [31:0]          base_in,
    input  logic [31:0]          exp_in,
    input  logic [MOD_WIDTH-1:0] mod_in,
    output rlm_pkg::rlm_status_t status,
    output logic [MOD_WIDTH:0]   acc
);
    localparam int CW = $clog2(MOD_WIDTH + 1) > 6 ? $clog2(MOD_WIDTH + 1) : 6;

    logic [31:0]          base_reg, base_next;
    logic [31:0]          exp_reg, exp_next;
    logic [MOD_WIDTH:0]   acc_reg, acc_next;
    // Interleaved multiply: r = (2r + a_bit*b) mod m, one bit of a per cycle.
    logic [MOD_WIDTH:0]   r_reg, r_next;
    logic [31:0]          a_reg, a_next;
    logic [MOD_WIDTH-1:0] b_reg, b_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 dst_reg, dst_next;   // 1: result to acc, 0: to base

    logic [MOD_WIDTH+2:0] t;
    logic [MOD_WIDTH+2:0] m_ext;
    logic [MOD_WIDTH+2:0] t1;

    always_comb
    begin
        m_ext = {3'b000, mod_in};
        t = {1'b0, r_reg, 1'b0} + (a_reg[31] ? {3'b000, b_reg} : '0);
        t1 = (t >= m_ext) ? t - m_ext : t;
        if (t1 >= m_ext)
            t1 = t1 - m_ext;
    end

    always_comb
    begin
        base_next = base_reg;
        exp_next  = exp_reg;
        acc_next  = acc_reg;
        r_next    = r_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        dst_next  = dst_reg;
        if (cmd.load)
        begin
            base_next = base_in;
            exp_next  = exp_in;
            acc_next  = {{MOD_WIDTH{1'b0}}, 1'b1};
        end
        if (cmd.shift_exp)
            exp_next = {1'b0, exp_reg[31:1]};
        if (cmd.red_start)
        begin
            // base mod m as base*1: 32 doublings of the base bits.
            r_next = '0; a_next = base_reg;
            b_next = {{(MOD_WIDTH-1){1'b0}}, 1'b1};
            cnt_next = CW'(32); run_next = 1'b1; dst_next = 1'b0;
        end
        if (cmd.mul_start)
        begin
            r_next = '0; a_next = 32'(acc_reg[MOD_WIDTH-1:0]);
            b_next = base_reg[MOD_WIDTH-1:0];
            cnt_next = CW'(32); run_next = 1'b1; dst_next = 1'b1;
        end
        if (cmd.sqr_start)
        begin
            r_next = '0; a_next = base_reg;
            b_next = base_reg[MOD_WIDTH-1:0];
            cnt_next = CW'(32); run_next = 1'b1; dst_next = 1'b0;
        end
        if (run_reg)
        begin
            r_next   = t1[MOD_WIDTH:0];
            a_next   = {a_reg[30:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                run_next = 1'b0;
                if (dst_reg)
                    acc_next = t1[MOD_WIDTH:0];
                else
                    base_next = 32'(t1[MOD_WIDTH:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_reg <= 1'b0;
        else
            run_reg <= run_next;
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        exp_reg  <= exp_next;
        acc_reg  <= acc_next;
        r_reg    <= r_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        cnt_reg  <= cnt_next;
        dst_reg  <= dst_next;
    end

    assign status.busy     = run_reg;
    assign status.exp_zero = (exp_reg == 32'd0);
    assign status.exp_lsb  = exp_reg[0];
    assign acc = acc_reg;
endmodule

FILE: hdl/rlm_ctrl.sv
// Controller state machine: handshakes, special cases and square-and-multiply sequencing.
module rlm_ctrl #(
    parameter int MOD_WIDTH = rlm_pkg::MOD_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    rlm_stream_if.sink           req,
    rlm_stream_if.source         rsp,
    input  logic [31:0]          pub_exp,
    input  logic [31:0]          priv_exp,
    input  logic [MOD_WIDTH-1:0] mod_val,
    input  rlm_pkg::rlm_status_t status,
    input  logic [MOD_WIDTH:0]   acc,
    output rlm_pkg::rlm_cmd_t    cmd,
    output logic [31:0]          base_out,
    output logic [31:0]          exp_out
);
    localparam logic [2:0] S_IDLE = 3'd0, S_RED = 3'd1, S_WRED = 3'd2, S_TEST = 3'd3,
                           S_WMUL = 3'd4, S_WSQR = 3'd5, S_DONE = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic        dec_reg, dec_next;
    logic        ovalid_reg, ovalid_next;
    logic [31:0] odata_reg, odata_next;
    logic        oflag_reg, oflag_next;
    logic [31:0] rdata_reg;
    logic        rflag_reg;
    logic [31:0] fin;

    always_comb
    begin
        fin = dec_reg ? {24'd0, 8'(acc[7:0] + rlm_pkg::LETTER_BASE[7:0])}
                      : 32'(acc);
    end

    always_comb
    begin
        state_next  = state_reg;
        dec_next    = dec_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        oflag_next  = oflag_reg;
        cmd         = '0;
        base_out    = req.flag ? req.data : req.data - rlm_pkg::LETTER_BASE;
        exp_out     = req.flag ? priv_exp : pub_exp;
        if (rsp.ready)
            ovalid_next = 1'b0;
        case (state_reg)
            S_IDLE:
                if (req.valid)
                begin
                    dec_next = req.flag;
                    if (!req.flag && req.data < rlm_pkg::LETTER_BASE)
                    begin
                        odata_next = '0; oflag_next = 1'b1; state_next = S_DONE;
                    end
                    else if (mod_val == '0)
                    begin
                        odata_next = req.flag ? rlm_pkg::LETTER_BASE : 32'd0;
                        oflag_next = 1'b0; state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.load = 1'b1; oflag_next = 1'b0; state_next = S_RED;
                    end
                end
            S_RED:
            begin
                cmd.red_start = 1'b1; state_next = S_WRED;
            end
            S_WRED:
                if (!status.busy)
                    state_next = S_TEST;
            S_TEST:
                if (status.exp_zero)
                begin
                    odata_next = fin; state_next = S_DONE;
                end
                else if (status.exp_lsb)
                begin
                    cmd.mul_start = 1'b1; state_next = S_WMUL;
                end
                else
                begin
                    cmd.sqr_start = 1'b1; cmd.shift_exp = 1'b1; state_next = S_WSQR;
                end
            S_WMUL:
                if (!status.busy)
                begin
                    cmd.sqr_start = 1'b1; cmd.shift_exp = 1'b1; state_next = S_WSQR;
                end
            S_WSQR:
                if (!status.busy)
                    state_next = S_TEST;
            S_DONE:
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1; state_next = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // The finished result waits in odata/oflag until the output register is free.
    always_ff @(posedge clk)
    begin
        dec_reg   <= dec_next;
        odata_reg <= odata_next;
        oflag_reg <= oflag_next;
        if (state_reg == S_DONE && (!ovalid_reg || rsp.ready))
        begin
            rdata_reg <= odata_reg;
            rflag_reg <= oflag_reg;
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = ovalid_reg;
    assign rsp.data  = rdata_reg;
    assign rsp.flag  = rflag_reg;
endmodule

FILE: hdl/rsa_letter_modexp.sv
// Top level of the RSA letter modular exponentiation block.
// Usage: requests arrive on req (flag = cmd, data = value); one result per request
// leaves on rsp (data = result, flag = bad_letter). Both use valid/ready and a
// transfer happens at a rising edge with valid and ready high.
// Configuration writes (cfg_we, cfg_idx, cfg_data) go to the public exponent (0),
// private exponent (1) and modulus (2); write only while the block is idle.
// Sequence: a bad letter or zero modulus goes straight to the result state.
// Otherwise the base is first reduced modulo the modulus, then each exponent bit up
// to the highest set one costs a squaring plus a multiply when the bit is set, all
// in the one shift-add modular multiplier, before the result is registered for
// output. One request is in work at a time; req.ready is high only while idle.
// The result register holds a waiting result while the receiver stalls; the next
// request may be taken and computed meanwhile, and waits to be delivered.
// Reset clears the handshake state and loads the registers with 17, 2753, 3233.
module rsa_letter_modexp #(
    parameter int MOD_WIDTH = rlm_pkg::MOD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    rlm_stream_if.sink                    req,
    rlm_stream_if.source                  rsp,
    input  logic                          cfg_we,
    input  logic [rlm_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [rlm_pkg::DATA_W-1:0]    cfg_data
);
    logic [31:0] pub_reg, priv_reg, mod_reg;
    rlm_pkg::rlm_cmd_t    cmd;
    rlm_pkg::rlm_status_t status;
    logic [MOD_WIDTH:0]   acc;
    logic [31:0]          base_v, exp_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pub_reg  <= 32'd17;
            priv_reg <= 32'd2753;
            mod_reg  <= 32'd3233;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                rlm_pkg::REG_PUB_EXP:  pub_reg  <= cfg_data;
                rlm_pkg::REG_PRIV_EXP: priv_reg <= cfg_data;
                rlm_pkg::REG_MODULUS:  mod_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    rlm_ctrl #(.MOD_WIDTH(MOD_WIDTH)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
        .pub_exp(pub_reg), .priv_exp(priv_reg), .mod_val(mod_reg[MOD_WIDTH-1:0]),
        .status(status), .acc(acc), .cmd(cmd), .base_out(base_v), .exp_out(exp_v)
    );

    rlm_datapath #(.MOD_WIDTH(MOD_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .base_in(base_v), .exp_in(exp_v),
        .mod_in(mod_reg[MOD_WIDTH-1:0]), .status(status), .acc(acc)
    );
endmodule
